FILE: src/bqrm_pkg.sv
`default_nettype none

package bqrm_pkg;

    // Default queue depth
    localparam int DEPTH_DEF = 8;

    // Field widths fixed by the interface
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 4;

    // Operation codes carried on s_tuser
    typedef enum logic {
        OP_ENQUEUE = 1'b0,
        OP_REMOVE  = 1'b1
    } op_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_OVERFLOW = 2'd1,
        STAT_EMPTY    = 2'd2,
        STAT_NOTFOUND = 2'd3
    } status_t;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_EMIT
    } state_t;

endpackage

`default_nettype wire

FILE: src/bounded_queue_remove_through_match.sv
`default_nettype none

// Channel   Ports                    Beat contents (low bit up)
// input     s_tvalid/s_tready        s_tuser: op; s_tdata: value
// result    m_tvalid/m_tready        m_tdata: status, count, dropped, zero pad
//
// An enqueue or a remove on an empty queue goes from acceptance straight to
// the emit state, which loads its result. A remove walks the entry memory
// through one read port and one equality compare: it compares the entries in
// order up to the match, then moves each surviving entry forward. The block
// takes no new beat until the result is loaded into the output register; a
// stalled result holds there.
// aresetn is synchronous, active low, and empties the queue.
module bounded_queue_remove_through_match
    import bqrm_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [VALUE_W-1:0] s_tdata,   // [31:0] value
    input  wire logic [0:0]         s_tuser,   // [0] op
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [15:0]             m_tdata    // [1:0] status, [5:2] count,
                                               // [9:6] dropped, [15:10] zero
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);
    localparam logic [CW-1:0] ONE  = CW'(1);

    // Entry storage
    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rd_data_reg;
    logic [IW-1:0]      rd_addr;
    logic [IW-1:0]      wr_addr;
    logic [VALUE_W-1:0] wr_data;
    logic               wr_en;

    state_t             state_reg, state_next;
    logic [CW-1:0]      fill_reg, fill_next;
    logic [CW-1:0]      ptr_reg, ptr_next;      // search index, then shift source
    logic [CW-1:0]      dst_reg, dst_next;
    logic [CW-1:0]      drop_reg, drop_next;
    logic [VALUE_W-1:0] key_reg, key_next;
    status_t            status_reg, status_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [15:0]        m_tdata_reg, m_tdata_next;

    logic               accept;
    logic               hit;
    logic               last_entry;
    logic               out_free;
    logic [CW-1:0]      ptr_inc;

    assign accept     = s_tvalid && s_tready;
    assign hit        = (rd_data_reg == key_reg);
    assign ptr_inc    = ptr_reg + ONE;
    assign last_entry = (ptr_inc == fill_reg);
    assign out_free   = !m_tvalid_reg || m_tready;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Write and read the entry memory
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_tuser[0] == OP_REMOVE && fill_reg != '0) begin
                        state_next = S_SEARCH;
                    end else begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_SEARCH: begin
                if (hit) begin
                    state_next = last_entry ? S_EMIT : S_SHIFT;
                end else if (last_entry) begin
                    state_next = S_EMIT;
                end
            end
            S_SHIFT: begin
                if (last_entry) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and result
    always_comb begin
        fill_next     = fill_reg;
        ptr_next      = ptr_reg;
        dst_next      = dst_reg;
        drop_next     = drop_reg;
        key_next      = key_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        rd_addr       = ptr_reg[IW-1:0];
        wr_en         = 1'b0;
        wr_addr       = fill_reg[IW-1:0];
        wr_data       = s_tdata;
        case (state_reg)
            S_IDLE: begin
                key_next  = s_tdata;
                ptr_next  = '0;
                dst_next  = '0;
                drop_next = '0;
                rd_addr   = '0;
                if (accept) begin
                    if (s_tuser[0] == OP_ENQUEUE) begin
                        if (fill_reg == FULL) begin
                            status_next = STAT_OVERFLOW;
                        end else begin
                            wr_en       = 1'b1;
                            fill_next   = fill_reg + ONE;
                            status_next = STAT_OK;
                        end
                    end else if (fill_reg == '0) begin
                        status_next = STAT_EMPTY;
                    end
                end
            end
            S_SEARCH: begin
                // compare one entry, fetch the next
                rd_addr  = ptr_inc[IW-1:0];
                ptr_next = ptr_inc;
                if (hit) begin
                    status_next = STAT_OK;
                    drop_next   = ptr_inc;
                    if (last_entry) begin
                        fill_next = '0;
                    end
                end else if (last_entry) begin
                    status_next = STAT_NOTFOUND;
                end
            end
            S_SHIFT: begin
                // move one survivor forward
                wr_en    = 1'b1;
                wr_addr  = dst_reg[IW-1:0];
                wr_data  = rd_data_reg;
                rd_addr  = ptr_inc[IW-1:0];
                ptr_next = ptr_inc;
                dst_next = dst_reg + ONE;
                if (last_entry) begin
                    fill_next = dst_reg + ONE;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'b0, COUNT_W'(drop_reg), COUNT_W'(fill_reg),
                                     status_reg};
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            fill_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        ptr_reg     <= ptr_next;
        dst_reg     <= dst_next;
        drop_reg    <= drop_next;
        key_reg     <= key_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FULL)
        else $error("fill exceeds queue depth");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg != S_IDLE)
        else $error("sequencer idle right after accepting a beat");

    a_shift_order: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SHIFT |-> ptr_reg > dst_reg)
        else $error("shift source not ahead of destination");

    a_drop_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[9:6] != 4'd0 |-> m_tdata[1:0] == STAT_OK)
        else $error("entries dropped on a failed step");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_EMIT && !out_free |=> state_reg == S_EMIT && m_tvalid)
        else $error("result left emit while output was stalled");
`endif

endmodule

`default_nettype wire
